[hw/rtl/fttq_pkg.sv]
package fttq_pkg;

	// Opcodes of an input item.
	localparam logic OP_SET  = 1'b0;
	localparam logic OP_POLL = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_RPM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TACH_CONSTANT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ADDR_A    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ADDR_B    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TACH_REG_BASE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TACH_REG_STEP  = 3'd5;
	localparam int CFG_DATA_W = 24;

	localparam int SLOT_W  = 3;
	localparam int SPEED_W = 8;
	localparam int RPM_W   = 16;
	localparam int DVD_W   = 24;
	localparam int PROD_W  = 24;
	localparam int COUNT_W = 13;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

	// Slots 0 to 2 sit on controller A, the rest on controller B.
	localparam logic [SLOT_W-1:0] SLOTS_PER_CTRL = 3'd3;

	// ceil(2^32 / 255): product * RECIP_255 >> 32 is exact for products below 2^24.
	localparam int RECIP_W = 25;
	localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;
	localparam int RECIP_SHIFT = 32;

	typedef struct packed {
		logic [15:0] full_scale_rpm;
		logic [23:0] tach_constant;
		logic [6:0]  ctrl_addr_a;
		logic [6:0]  ctrl_addr_b;
		logic [7:0]  tach_reg_base;
		logic [7:0]  tach_reg_stride;
	} cfg_t;

	typedef struct packed {
		logic               is_poll;
		logic [SLOT_W-1:0]  slot;
		logic [SPEED_W-1:0] speed;
	} cmd_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [RPM_W-1:0]  divisor;
	} div_req_t;

	// Position of a fan on its controller.
	function automatic logic [1:0] slot_mod3(input logic [SLOT_W-1:0] slot);
		logic [1:0] r;
		case (slot)
			3'd0, 3'd3, 3'd6: r = 2'd0;
			3'd1, 3'd4, 3'd7: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/fttq_front.sv]
module fttq_front
	import fttq_pkg::*;
#(
	parameter int NUM_FANS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [SLOT_W-1:0]  fan_slot,
	input  logic [SPEED_W-1:0] speed_byte,
	output logic               cmd_valid,
	output cmd_t               cmd,
	input  logic               cmd_pop
);

	localparam int DEPTH = 2;

	cmd_t       fifo_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       keep;
	logic       push;
	logic       pop;

	// A set aimed at a slot that does not exist is taken and dropped here.
	assign keep = (opcode == OP_POLL) || ({2'b00, fan_slot} < 5'(NUM_FANS));

	assign in_ready  = (count_q != 2'(DEPTH));
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{is_poll: (opcode == OP_POLL), slot: fan_slot,
				speed: speed_byte};
		end
	end

endmodule

[hw/rtl/fttq_div.sv]
module fttq_div
	import fttq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RPM_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [RPM_W-1:0]  dsr_q;
	logic [RPM_W:0]    trial;
	logic [RPM_W:0]    diff;
	logic              fits;

	// Restoring division, one quotient bit per cycle, MSB first.
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[RPM_W-1:0] : trial[RPM_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

endmodule

[hw/rtl/fttq_back.sv]
module fttq_back
	import fttq_pkg::*;
#(
	parameter int NUM_FANS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_pop,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [SLOT_W-1:0]  job_slot,
	output logic [6:0]         target_controller,
	output logic [7:0]         low_reg_addr,
	output logic [7:0]         count_low_byte,
	output logic [7:0]         high_reg_addr,
	output logic [7:0]         count_high_byte
);

	localparam int IDX_W  = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
	localparam int FULL_W = PROD_W + RECIP_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RECIP = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_DIV   = 4'b1000
	} back_state_t;

	back_state_t         state_q;
	logic [NUM_FANS-1:0] pending_q;
	logic                out_valid_q;
	logic [PROD_W-1:0]   prod_q;
	logic [RPM_W-1:0]    rpm_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  slot_count_q [NUM_FANS];

	logic [FULL_W-1:0]   rpm_full;
	logic                out_free;
	logic                take_poll;
	logic                hit;
	logic [IDX_W-1:0]    hit_idx;
	logic [SLOT_W-1:0]   hit_slot;
	logic [COUNT_W-1:0]  hit_count;
	logic [7:0]          low_reg;
	logic [7:0]          step_off;
	logic                wr_count;
	logic [COUNT_W-1:0]  wr_value;
	div_req_t            div_req;
	logic                div_done;
	logic [DVD_W-1:0]    div_quo;

	fttq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign rpm_full = FULL_W'(prod_q) * FULL_W'(RECIP_255);

	assign out_free  = !out_valid_q || out_ready;
	assign take_poll = (state_q == ST_IDLE) && cmd_valid && cmd.is_poll && out_free;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid && (!cmd.is_poll || out_free);

	// Lowest-numbered pending slot.
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		hit_slot = '0;
		for (int i = NUM_FANS - 1; i >= 0; i--) begin
			if (pending_q[i]) begin
				hit      = 1'b1;
				hit_idx  = IDX_W'(i);
				hit_slot = SLOT_W'(i);
			end
		end
	end

	assign hit_count = slot_count_q[hit_idx];

	always_comb begin
		case (slot_mod3(hit_slot))
			2'd0:    step_off = 8'd0;
			2'd1:    step_off = cfg.tach_reg_stride;
			default: step_off = {cfg.tach_reg_stride[6:0], 1'b0};
		endcase
	end
	assign low_reg = cfg.tach_reg_base + step_off;

	assign div_req.start    = (state_q == ST_CHECK) && (rpm_q != '0);
	assign div_req.dividend = cfg.tach_constant;
	assign div_req.divisor  = rpm_q;

	always_comb begin
		wr_count = 1'b0;
		wr_value = COUNT_MAX;
		if ((state_q == ST_CHECK) && (rpm_q == '0)) begin
			wr_count = 1'b1;
		end else if ((state_q == ST_DIV) && div_done) begin
			wr_count = 1'b1;
			wr_value = (|div_quo[DVD_W-1:COUNT_W]) ? COUNT_MAX : div_quo[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pending_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_poll && hit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && !cmd.is_poll) begin
						state_q <= ST_RECIP;
					end else if (take_poll && hit) begin
						pending_q[hit_idx] <= 1'b0;
					end
				end
				ST_RECIP: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= (rpm_q == '0) ? ST_IDLE : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (wr_count) begin
				pending_q[IDX_W'(slot_q)] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && cmd_valid && !cmd.is_poll) begin
			prod_q <= PROD_W'(cmd.speed) * PROD_W'(cfg.full_scale_rpm);
			slot_q <= cmd.slot;
		end
		if (state_q == ST_RECIP) begin
			rpm_q <= rpm_full[RECIP_SHIFT +: RPM_W];
		end
		if (wr_count) begin
			slot_count_q[IDX_W'(slot_q)] <= wr_value;
		end
		if (take_poll && hit) begin
			job_slot          <= hit_slot;
			target_controller <= (hit_slot < SLOTS_PER_CTRL) ? cfg.ctrl_addr_a
				: cfg.ctrl_addr_b;
			low_reg_addr      <= low_reg;
			high_reg_addr     <= low_reg + 8'd1;
			count_low_byte    <= {hit_count[4:0], 3'b000};
			count_high_byte   <= hit_count[COUNT_W-1:5];
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/fan_tach_target_job_queue.sv]
// Fan tach target job queue. A set item (opcode 0) turns a speed byte into a
// 13-bit tach target count for one fan slot and marks that slot pending,
// replacing any older job for it; sets to slots at or above NUM_FANS are
// taken and dropped. A poll item (opcode 1) emits the lowest-numbered pending
// job on the output channel and clears it, or emits nothing if no slot is
// pending. Items enter a two-entry queue, so the input can take up to two
// items while the back end is busy or the output is stalled. A set passes
// through the back end step by step: the first forms speed times the
// full-scale rpm, the next divides that by 255 through a reciprocal
// multiply, the next checks for zero rpm, the serial divider then works out
// tach_constant / rpm one quotient bit at a time, and a last step stores the
// count. Zero rpm skips the divider and stores 8191 at the zero check; a
// quotient above 8191 is saturated to 8191. A poll is taken once the output
// register is free. Register addresses and the controller address come from
// the configuration at poll time, while the count keeps the value computed at
// set time. Configuration registers are written through cfg_we, cfg_idx and
// cfg_wdata; indexes beyond the register list are ignored.
module fan_tach_target_job_queue
	import fttq_pkg::*;
#(
	parameter int NUM_FANS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [SLOT_W-1:0]     fan_slot,
	input  logic [SPEED_W-1:0]    speed_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SLOT_W-1:0]     job_slot,
	output logic [6:0]            target_controller,
	output logic [7:0]            low_reg_addr,
	output logic [7:0]            count_low_byte,
	output logic [7:0]            high_reg_addr,
	output logic [7:0]            count_high_byte
);

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	// Configuration registers, each masked to its own width on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_scale_rpm  <= 16'd5000;
			cfg_q.tach_constant   <= 24'd7864320;
			cfg_q.ctrl_addr_a     <= 7'h2E;
			cfg_q.ctrl_addr_b     <= 7'h2F;
			cfg_q.tach_reg_base   <= 8'h3C;
			cfg_q.tach_reg_stride <= 8'd16;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FULL_SCALE_RPM: cfg_q.full_scale_rpm  <= cfg_wdata[15:0];
				CFG_TACH_CONSTANT:  cfg_q.tach_constant   <= cfg_wdata[23:0];
				CFG_CTRL_ADDR_A:    cfg_q.ctrl_addr_a     <= cfg_wdata[6:0];
				CFG_CTRL_ADDR_B:    cfg_q.ctrl_addr_b     <= cfg_wdata[6:0];
				CFG_TACH_REG_BASE:  cfg_q.tach_reg_base   <= cfg_wdata[7:0];
				CFG_TACH_REG_STEP:  cfg_q.tach_reg_stride <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// The front end classifies items and buffers them in order.
	fttq_front #(
		.NUM_FANS (NUM_FANS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.fan_slot   (fan_slot),
		.speed_byte (speed_byte),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	// The back end computes counts, keeps the pending table and drives results.
	fttq_back #(
		.NUM_FANS (NUM_FANS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.job_slot          (job_slot),
		.target_controller (target_controller),
		.low_reg_addr      (low_reg_addr),
		.count_low_byte    (count_low_byte),
		.high_reg_addr     (high_reg_addr),
		.count_high_byte   (count_high_byte)
	);

endmodule

[hw/rtl/fttq_checker.sv]
module fttq_checker
	import fttq_pkg::*;
#(
	parameter int NUM_FANS = 6
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [SLOT_W-1:0] job_slot,
	input logic [7:0]        low_reg_addr,
	input logic [7:0]        count_low_byte,
	input logic [7:0]        high_reg_addr,
	input logic [7:0]        count_high_byte
);

	// A stalled item keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(job_slot)
			&& $stable(count_low_byte) && $stable(count_high_byte))
		else $error("output item changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> high_reg_addr == 8'(low_reg_addr + 8'd1))
		else $error("high register address is not low address plus one");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_low_byte[2:0] == 3'b000)
		else $error("low count byte has bits below bit three set");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {2'b00, job_slot} < 5'(NUM_FANS))
		else $error("job emitted for a slot that does not exist");

endmodule

bind fan_tach_target_job_queue fttq_checker #(
	.NUM_FANS (NUM_FANS)
) u_fttq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.job_slot        (job_slot),
	.low_reg_addr    (low_reg_addr),
	.count_low_byte  (count_low_byte),
	.high_reg_addr   (high_reg_addr),
	.count_high_byte (count_high_byte)
);
